>>> rtl/core/slir_pkg.sv
// ----------------------------------------------------------------------------
// slir_pkg
// Types and codes shared by the sorted list store controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package slir_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 3;

  typedef enum logic [OpW-1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_READOUT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_INS_PUT,
    S_REM_CHK,
    S_REM_CMP,
    S_SHF_CHK,
    S_SHF_MOV,
    S_RD_REQ,
    S_RD_CAP,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_SET_CNT,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,    // mem[idx]   <= read data
    WR_PUT,   // mem[idx]   <= held value
    WR_DOWN   // mem[idx-1] <= read data
  } wr_op_t;

  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    cnt_op_t cnt_op;
    logic    rd_en;
    logic    rd_prev;   // read at idx-1 instead of idx
    wr_op_t  wr_op;
    logic    out_set;
    logic    out_entry; // result carries read data and end-of-list flag
    status_t out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic idx_zero;
    logic idx_at_cnt;
    logic rd_gt;
    logic rd_eq;
    logic out_last;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/slir_ram.sv
// ----------------------------------------------------------------------------
// slir_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module slir_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/slir_datapath.sv
// ----------------------------------------------------------------------------
// slir_datapath
// Entry store, scan index, entry count, held operand and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module slir_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire slir_pkg::dp_cmd_t             cmd,
  input  wire logic [slir_pkg::ValueW-1:0]   in_value,
  output slir_pkg::dp_stat_t                 stat,
  output logic [slir_pkg::StatusW-1:0]       out_status,
  output logic [slir_pkg::ValueW-1:0]        out_value,
  output logic                               out_last
);

  import slir_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);
  localparam logic [CW-1:0] OneC = CW'(1);

  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [ValueW-1:0] value_r;
  logic [CW-1:0]     idx_m1;
  logic [CW-1:0]     idx_p1;
  logic [ValueW-1:0] rdata;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [ValueW-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [StatusW-1:0] status_r;
  logic [ValueW-1:0] res_value_r;
  logic              res_last_r;

  assign idx_m1 = idx_r - OneC;
  assign idx_p1 = idx_r + OneC;

  always_comb begin
    idx_nxt = idx_r;
    case (cmd.idx_op)
      IDX_CLR:     idx_nxt = '0;
      IDX_SET_CNT: idx_nxt = cnt_r;
      IDX_INC:     idx_nxt = idx_p1;
      IDX_DEC:     idx_nxt = idx_m1;
      default:     idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    case (cmd.cnt_op)
      CNT_INC: cnt_nxt = cnt_r + OneC;
      CNT_DEC: cnt_nxt = cnt_r - OneC;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
    end
    if (cmd.out_set) begin
      status_r    <= cmd.out_status;
      res_value_r <= cmd.out_entry ? rdata : '0;
      res_last_r  <= cmd.out_entry ? (idx_p1 == cnt_r) : 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = rdata;
    case (cmd.wr_op)
      WR_UP: begin
        we = 1'b1;
      end
      WR_PUT: begin
        we    = 1'b1;
        wdata = value_r;
      end
      WR_DOWN: begin
        we    = 1'b1;
        waddr = idx_m1[AW-1:0];
      end
      default: we = 1'b0;
    endcase
  end

  assign raddr = cmd.rd_prev ? idx_m1[AW-1:0] : idx_r[AW-1:0];

  slir_ram #(
    .WIDTH(ValueW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign stat.full       = (cnt_r >= CapC);
  assign stat.cnt_zero   = (cnt_r == '0);
  assign stat.idx_zero   = (idx_r == '0);
  assign stat.idx_at_cnt = (idx_r == cnt_r);
  assign stat.rd_gt      = ($signed(rdata) > $signed(value_r));
  assign stat.rd_eq      = (rdata == value_r);
  assign stat.out_last   = res_last_r;

  assign out_status = status_r;
  assign out_value  = res_value_r;
  assign out_last   = res_last_r;

endmodule

`default_nettype wire

>>> rtl/core/slir_ctrl.sv
// ----------------------------------------------------------------------------
// slir_ctrl
// Sequencer for insert, remove and readout over the entry store.
// ----------------------------------------------------------------------------
`default_nettype none

module slir_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [slir_pkg::OpW-1:0]  in_op,
  output logic                           in_ready,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  input  wire slir_pkg::dp_stat_t        stat,
  output slir_pkg::dp_cmd_t              cmd
);

  import slir_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;
  op_t    op;

  assign op     = op_t'(in_op);
  assign accept = in_valid && rst_n && (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_INSERT:  state_nxt = stat.full ? S_OUT : S_INS_CHK;
            OP_REMOVE:  state_nxt = S_REM_CHK;
            OP_READOUT: state_nxt = stat.cnt_zero ? S_OUT : S_RD_REQ;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_CHK: state_nxt = stat.idx_zero ? S_INS_PUT : S_INS_CMP;
      S_INS_CMP: state_nxt = stat.rd_gt ? S_INS_CHK : S_INS_PUT;
      S_INS_PUT: state_nxt = S_OUT;
      S_REM_CHK: state_nxt = stat.idx_at_cnt ? S_OUT : S_REM_CMP;
      S_REM_CMP: state_nxt = stat.rd_eq ? S_SHF_CHK : S_REM_CHK;
      S_SHF_CHK: state_nxt = stat.idx_at_cnt ? S_OUT : S_SHF_MOV;
      S_SHF_MOV: state_nxt = S_SHF_CHK;
      S_RD_REQ:  state_nxt = S_RD_CAP;
      S_RD_CAP:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          state_nxt = stat.out_last ? S_IDLE : S_RD_REQ;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.idx_op     = IDX_HOLD;
    cmd.cnt_op     = CNT_HOLD;
    cmd.wr_op      = WR_NONE;
    cmd.out_status = ST_INSERTED;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        cmd.load = accept;
        if (accept) begin
          unique case (op)
            OP_INSERT: begin
              if (stat.full) begin
                cmd.out_set    = 1'b1;
                cmd.out_status = ST_FULL;
              end else begin
                cmd.idx_op = IDX_SET_CNT;
              end
            end
            OP_REMOVE: cmd.idx_op = IDX_CLR;
            OP_READOUT: begin
              if (stat.cnt_zero) begin
                cmd.out_set    = 1'b1;
                cmd.out_status = ST_EMPTY;
              end else begin
                cmd.idx_op = IDX_CLR;
              end
            end
            default: cmd.load = 1'b0;
          endcase
        end
      end
      S_INS_CHK: begin
        cmd.rd_en   = !stat.idx_zero;
        cmd.rd_prev = 1'b1;
      end
      S_INS_CMP: begin
        if (stat.rd_gt) begin
          cmd.wr_op  = WR_UP;
          cmd.idx_op = IDX_DEC;
        end
      end
      S_INS_PUT: begin
        cmd.wr_op      = WR_PUT;
        cmd.cnt_op     = CNT_INC;
        cmd.out_set    = 1'b1;
        cmd.out_status = ST_INSERTED;
      end
      S_REM_CHK: begin
        if (stat.idx_at_cnt) begin
          cmd.out_set    = 1'b1;
          cmd.out_status = ST_NOTFOUND;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      S_REM_CMP: cmd.idx_op = IDX_INC;
      S_SHF_CHK: begin
        if (stat.idx_at_cnt) begin
          cmd.cnt_op     = CNT_DEC;
          cmd.out_set    = 1'b1;
          cmd.out_status = ST_REMOVED;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      S_SHF_MOV: begin
        cmd.wr_op  = WR_DOWN;
        cmd.idx_op = IDX_INC;
      end
      S_RD_REQ: cmd.rd_en = 1'b1;
      S_RD_CAP: begin
        cmd.out_set    = 1'b1;
        cmd.out_entry  = 1'b1;
        cmd.out_status = ST_ENTRY;
        cmd.idx_op     = IDX_INC;
      end
      S_OUT: out_valid = 1'b1;
      default: cmd.load = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/sorted_list_insert_remove_top.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_top
// Bounded sorted store of signed 32-bit values with insert, remove, readout.
//
// Input channel (in_*): in_tuser carries the opcode (insert, remove, readout),
// in_tdata the value. An opcode of three is taken and dropped without result.
// Result channel (out_*): out_tuser is the status, out_tdata the entry value
// (zero unless the status is entry), out_tlast marks the final result of an
// item. Insert and remove give one result; readout gives one per entry, or
// one list-empty result.
// One item at a time: in_tready is high only while the sequencer is idle and
// out of reset.
// The RAM read is registered, so each scan step is a read state followed by
// a compare or move state. Insert scans down from the end, moving each larger
// entry up; remove searches from the front, then moves later entries down; a
// refused insert or an empty readout goes straight to the result. Readout
// reads the entries in order from the front. Results wait in a register
// until taken; the sequencer holds while out_tready is low. Reset empties the
// store at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_remove_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] entry_value
  output logic [2:0]       out_tuser,  // [2:0] status
  output logic             out_tlast
);

  import slir_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  slir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slir_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_value  (in_tdata),
    .stat      (stat),
    .out_status(out_tuser),
    .out_value (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

>>> verif/sorted_list_insert_remove_top_test.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_top_test
// Self-checking bench for the bounded sorted store. Items go in on the in_*
// stream with random gaps. A shadow copy of the list predicts each status,
// readout entry and end marker, and every result on the out_* stream, taken
// under random back-pressure, is checked in order against that prediction.
// Directed cases cover the empty store, extreme and duplicate values and the
// ignored opcode. Random fill and drain rounds follow; some run the store
// full, so inserts are refused.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_top_test;
  import slir_pkg::*;

  localparam int unsigned Capacity   = 16;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 200;
  localparam int unsigned RandomOps  = 60;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
    logic        last;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] value
  logic [1:0]  in_tuser = '0;   // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] entry_value
  logic [2:0]  out_tuser;       // [2:0] status
  logic        out_tlast;

  list_result_t awaited_results[$];
  logic [31:0]  list_vals[Capacity];
  int unsigned  list_len = 0;
  int unsigned  list_ops_sent = 0;
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  ready_hold = 0;
  bit           idle_on = 1'b1;

  sorted_list_insert_remove_top #(.CAPACITY(Capacity)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sorted_list_insert_remove_top_test: FAIL");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_value(bit narrow);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (narrow) return 32'($signed($urandom_range(0, 8)) - 4);
    case (r)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_result(status_t st, logic [31:0] v, logic lst);
    list_result_t r;
    r.status = st;
    r.value  = v;
    r.last   = lst;
    awaited_results.push_back(r);
  endfunction

  // shadow list update and result prediction for one accepted item
  function automatic void apply_to_list(op_t op, logic [31:0] v);
    int unsigned pos;
    case (op)
      OP_INSERT: begin
        if (list_len >= Capacity) begin
          push_result(ST_FULL, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < list_len && !($signed(v) < $signed(list_vals[pos]))) pos++;
          for (int unsigned i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = v;
          list_len++;
          push_result(ST_INSERTED, '0, 1'b1);
        end
      end
      OP_REMOVE: begin
        pos = 0;
        while (pos < list_len && list_vals[pos] != v) pos++;
        if (pos >= list_len) begin
          push_result(ST_NOTFOUND, '0, 1'b1);
        end else begin
          for (int unsigned i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
          push_result(ST_REMOVED, '0, 1'b1);
        end
      end
      OP_READOUT: begin
        if (list_len == 0) push_result(ST_EMPTY, '0, 1'b1);
        for (int unsigned i = 0; i < list_len; i++)
          push_result(ST_ENTRY, list_vals[i], i + 1 == list_len);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(op_t op, logic [31:0] v);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 1)) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    apply_to_list(op, v);
    if (op != OP_NONE) list_ops_sent++;
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      if (!idle_on || $urandom_range(0, 1)) begin
        out_tready <= 1'b1;
        ready_hold = $urandom_range(1, 8);
      end else begin
        out_tready <= 1'b0;
        ready_hold = pick_gap();
      end
    end else begin
      ready_hold--;
    end
  end

  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: status %0d value %h last %b",
                   out_tuser, out_tdata, out_tlast);
      end else begin
        exp_r = awaited_results.pop_front();
        if (out_tuser !== exp_r.status || out_tdata !== exp_r.value ||
            out_tlast !== exp_r.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"mismatch: expected status %0d value %h last %b, ",
                      "got status %0d value %h last %b"},
                     exp_r.status, exp_r.value, exp_r.last, out_tuser, out_tdata, out_tlast);
        end
      end
    end
  end

  task automatic test_empty_list();
    send_item(OP_READOUT, $urandom);
    send_item(OP_REMOVE, 32'h0000_0000);
    send_item(OP_NONE, $urandom);
    send_item(OP_REMOVE, 32'h8000_0000);
    send_item(OP_NONE, 32'hFFFF_FFFF);
    send_item(OP_READOUT, 32'hFFFF_FFFF);
  endtask

  task automatic test_order_and_extremes();
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0001);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_READOUT, 32'h0);
    send_item(OP_REMOVE, 32'h0000_0000);
    send_item(OP_REMOVE, 32'h1234_5678);
    send_item(OP_REMOVE, 32'h8000_0000);
    send_item(OP_REMOVE, 32'h7FFF_FFFF);
    send_item(OP_READOUT, 32'h0);
    send_item(OP_REMOVE, 32'h7FFF_FFFF);
    send_item(OP_REMOVE, 32'hFFFF_FFFF);
    send_item(OP_REMOVE, 32'h0000_0001);
    send_item(OP_REMOVE, 32'h0000_0000);
    send_item(OP_READOUT, 32'h0);
  endtask

  // fill and drain rounds; the first round always runs into a full store
  task automatic test_random_churn();
    int unsigned round_idx;
    int unsigned fill_to;
    int unsigned drain_to;
    int unsigned r;
    bit          narrow;
    round_idx = 0;
    list_ops_sent = 0;
    while (list_ops_sent < RandomOps) begin
      idle_on = (round_idx % 4 != 2);
      narrow  = $urandom_range(0, 1);
      fill_to = (round_idx == 0 || $urandom_range(0, 2) == 0) ? Capacity
                                                               : $urandom_range(1, Capacity - 1);
      while (list_len < fill_to) begin
        r = $urandom_range(0, 9);
        if (r == 0) send_item(OP_NONE, $urandom);
        else if (r == 1) send_item(OP_REMOVE, pick_value(narrow));
        else if (r == 2) send_item(OP_READOUT, $urandom);
        else send_item(OP_INSERT, pick_value(narrow));
      end
      if (list_len == Capacity) begin
        repeat ($urandom_range(1, 2)) send_item(OP_INSERT, pick_value(narrow));
      end
      send_item(OP_READOUT, $urandom);
      drain_to = $urandom_range(0, 1) ? 0 : $urandom_range(0, list_len);
      while (list_len > drain_to) begin
        r = $urandom_range(0, 9);
        if (r == 0) send_item(OP_NONE, $urandom);
        else if (r == 1) send_item(OP_REMOVE, pick_value(narrow));
        else if (r == 2) send_item(OP_READOUT, $urandom);
        else if (r == 3) send_item(OP_INSERT, pick_value(narrow));
        else send_item(OP_REMOVE, list_vals[$urandom_range(0, list_len - 1)]);
      end
      send_item(OP_READOUT, $urandom);
      round_idx++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_order_and_extremes();
    test_random_churn();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("sorted_list_insert_remove_top_test: PASS");
    end else begin
      $display("sorted_list_insert_remove_top_test: FAIL");
    end
    $finish;
  end

endmodule
